>>> hw/rtl/fgp_pkg.sv
package fgp_pkg;

  localparam int QUO_W     = 32;
  localparam int VX_W      = 44;
  localparam int VZ_W      = 27;
  localparam int ANG_W     = 28;
  localparam int CS_W      = 32;
  localparam int CFG_W     = 24;
  localparam int CFG_IDX_W = 3;

  localparam int ATAN_ENTRIES = 24;
  // atan(2^-i) in units of 2^-24 rad
  localparam int ATAN_TAB [ATAN_ENTRIES] = '{
    13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
    65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32,
    16, 8, 4, 2
  };

  localparam int ANG_PI      = 52707179;
  localparam int ANG_HALF_PI = 26353589;
  localparam int ANG_TWO_PI  = 105414357;
  localparam int GAIN_INV    = 652032874;

  localparam logic [QUO_W-1:0] POS_LIM = 32'h7fff_ffff;
  localparam logic [QUO_W-1:0] NEG_LIM = 32'h8000_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PRINCIPAL_COL = 3'd0,
    REG_PRINCIPAL_ROW = 3'd1,
    REG_FOCAL_LENGTH  = 3'd2,
    REG_CAMERA_HEIGHT = 3'd3,
    REG_PITCH_ANGLE   = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [11:0] pixel_row;
    logic [11:0] pixel_col;
    logic [7:0]  blue;
    logic [7:0]  green;
    logic [7:0]  red;
  } pixel_t;

  typedef struct packed {
    logic signed [31:0] ground_forward;
    logic signed [31:0] ground_lateral;
    logic [7:0]         out_blue;
    logic [7:0]         out_green;
    logic [7:0]         out_red;
    logic               saturated;
  } ground_t;

endpackage

>>> hw/rtl/flat_ground_pixel_projection.sv
// Maps each camera pixel to a point on a flat ground plane (forward and
// lateral distance, Q16.16 m) and passes its colour through. A pixel is
// taken in every clock cycle and busy never rises; the result appears
// with done high for one cycle, and the receiver cannot stall it. The
// path runs through the arctangent CORDIC pipeline, the sine/cosine
// CORDIC pipeline and two 33-stage dividers, an overflow stage and then
// one quotient bit per stage. The user must write the configuration
// registers only while no pixel is in flight; it is not enforced.
module flat_ground_pixel_projection #(
  parameter int COORD_BITS   = 12,
  parameter int CORDIC_STEPS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  fgp_pkg::pixel_t                   pixel,
  output logic                              done,
  output fgp_pkg::ground_t                  result,
  input  logic                              cfg_we,
  input  logic [fgp_pkg::CFG_IDX_W-1:0]     cfg_addr,
  input  logic [fgp_pkg::CFG_W-1:0]         cfg_wdata
);
  import fgp_pkg::*;

  localparam int USE_BITS = (COORD_BITS < 12) ? COORD_BITS : 12;
  localparam logic [11:0] COORD_MASK = 12'((1 << USE_BITS) - 1);
  localparam int C_W    = 18;
  localparam int SIDE_W = C_W + 24;
  localparam int HCA_W  = 56;
  localparam int HC_W   = 41;
  localparam int CT_W   = 17;
  localparam int NUMY_W = 58;
  localparam int NY_W   = NUMY_W + 15;
  localparam int DENX_W = 31;
  localparam int DENY_W = 51;
  localparam logic signed [ANG_W-1:0] PI_A  = ANG_W'(ANG_PI);
  localparam logic signed [ANG_W-1:0] TPI_A = ANG_W'(ANG_TWO_PI);

  // configuration registers
  logic [15:0]        cfg_pcol;
  logic [15:0]        cfg_prow;
  logic [19:0]        cfg_focal;
  logic [23:0]        cfg_height;
  logic signed [15:0] cfg_pitch;
  logic [19:0]        fx_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_pcol   <= 16'd20736;
      cfg_prow   <= 16'd15552;
      cfg_focal  <= 20'd32768;
      cfg_height <= 24'd65536;
      cfg_pitch  <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_addr))
        REG_PRINCIPAL_COL: begin
          cfg_pcol <= cfg_wdata[15:0];
        end
        REG_PRINCIPAL_ROW: begin
          cfg_prow <= cfg_wdata[15:0];
        end
        REG_FOCAL_LENGTH: begin
          cfg_focal <= cfg_wdata[19:0];
        end
        REG_CAMERA_HEIGHT: begin
          cfg_height <= cfg_wdata;
        end
        REG_PITCH_ANGLE: begin
          cfg_pitch <= cfg_wdata[15:0];
        end
        default: begin
        end
      endcase
    end
  end

  assign fx_eff = (cfg_focal == '0) ? 20'd1 : cfg_focal;
  assign busy   = 1'b0;

  // entry stage: centred coordinates in 1/16 pixel
  logic [11:0]           row_m;
  logic [11:0]           col_m;
  logic                  s0_valid;
  logic signed [C_W-1:0] s0_r16;
  logic signed [C_W-1:0] s0_c16;
  logic [23:0]           s0_rgb;

  assign row_m = pixel.pixel_row & COORD_MASK;
  assign col_m = pixel.pixel_col & COORD_MASK;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else begin
      s0_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    s0_r16 <= $signed({2'b00, cfg_prow}) + 18'sd8 - $signed({2'b00, row_m, 4'b0000});
    s0_c16 <= $signed({2'b00, col_m, 4'b0000}) - $signed({2'b00, cfg_pcol}) + 18'sd8;
    s0_rgb <= {pixel.blue, pixel.green, pixel.red};
  end

  // ray angle
  logic signed [VX_W-1:0] vec_x;
  logic signed [VX_W-1:0] vec_y;
  logic                   vec_valid;
  logic signed [VZ_W-1:0] vec_z;
  logic [SIDE_W-1:0]      vec_side;

  assign vec_x = VX_W'({fx_eff, 20'd0});
  assign vec_y = VX_W'(s0_r16) <<< 20;

  fgp_cordic_vec #(
    .STEPS  (CORDIC_STEPS),
    .SIDE_W (SIDE_W)
  ) u_vec (
    .clk       (clk),
    .rst       (rst),
    .valid_in  (s0_valid),
    .x_in      (vec_x),
    .y_in      (vec_y),
    .side_in   ({s0_c16, s0_rgb}),
    .valid_out (vec_valid),
    .z_out     (vec_z),
    .side_out  (vec_side)
  );

  // pitch plus ray angle, wrapped into [-pi, pi)
  logic signed [ANG_W-1:0] sum_a;
  logic signed [ANG_W-1:0] wrap_a;
  logic                    sw_valid;
  logic signed [ANG_W-1:0] sw_ang [2];
  logic [SIDE_W-1:0]       sw_side;

  always_comb begin
    sum_a = (ANG_W'(cfg_pitch) <<< 11) - ANG_W'(vec_z);
    if (sum_a >= PI_A) begin
      wrap_a = sum_a - TPI_A;
    end else if (sum_a < -PI_A) begin
      wrap_a = sum_a + TPI_A;
    end else begin
      wrap_a = sum_a;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sw_valid <= 1'b0;
    end else begin
      sw_valid <= vec_valid;
    end
  end

  always_ff @(posedge clk) begin
    sw_ang[0] <= wrap_a;
    sw_ang[1] <= -ANG_W'(vec_z);
    sw_side   <= vec_side;
  end

  // cos/sin of the ground angle and cos of the ray angle
  logic                   rot_valid;
  logic signed [CS_W-1:0] rot_cos [2];
  logic signed [CS_W-1:0] rot_sin [2];
  logic [SIDE_W-1:0]      rot_side;

  fgp_cordic_rot #(
    .STEPS  (CORDIC_STEPS),
    .SIDE_W (SIDE_W)
  ) u_rot (
    .clk       (clk),
    .rst       (rst),
    .valid_in  (sw_valid),
    .ang_in    (sw_ang),
    .side_in   (sw_side),
    .valid_out (rot_valid),
    .cos_out   (rot_cos),
    .sin_out   (rot_sin),
    .side_out  (rot_side)
  );

  // p1: signs, magnitudes, rounded cos of the ray angle
  logic signed [C_W-1:0]  rot_c16;
  logic signed [CS_W:0]   ct_rnd;
  logic                   p1_valid;
  logic                   p1_horizon;
  logic                   p1_ca_neg;
  logic                   p1_y_neg;
  logic [CS_W-1:0]        p1_ca_abs;
  logic [C_W-2:0]         p1_cabs;
  logic [CT_W-1:0]        p1_ct15;
  logic [DENX_W-1:0]      p1_denx;
  logic [23:0]            p1_rgb;

  assign rot_c16 = rot_side[SIDE_W-1:24];
  assign ct_rnd  = (CS_W+1)'(rot_cos[1]) + 33'sd16384;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else begin
      p1_valid <= rot_valid;
    end
  end

  always_ff @(posedge clk) begin
    p1_horizon <= rot_sin[0] <= 0;
    p1_ca_neg  <= rot_cos[0][CS_W-1];
    p1_ca_abs  <= rot_cos[0][CS_W-1] ? CS_W'(-rot_cos[0]) : CS_W'(rot_cos[0]);
    p1_y_neg   <= rot_c16 > 0;
    p1_cabs    <= rot_c16[C_W-1] ? (C_W-1)'(-rot_c16) : (C_W-1)'(rot_c16);
    p1_ct15    <= ct_rnd[CS_W] ? '0 : ct_rnd[CS_W-1:15];
    p1_denx    <= rot_sin[0][DENX_W-1:0];
    p1_rgb     <= rot_side[23:0];
  end

  // p2: first products
  logic                p2_valid;
  logic                p2_horizon;
  logic                p2_ca_neg;
  logic                p2_y_neg;
  logic [HCA_W-1:0]    p2_hca;
  logic [HC_W-1:0]     p2_hc;
  logic [CT_W-1:0]     p2_ct15;
  logic [DENX_W-1:0]   p2_denx;
  logic [DENY_W-1:0]   p2_deny;
  logic [23:0]         p2_rgb;

  always_ff @(posedge clk) begin
    if (rst) begin
      p2_valid <= 1'b0;
    end else begin
      p2_valid <= p1_valid;
    end
  end

  always_ff @(posedge clk) begin
    p2_hca     <= HCA_W'(cfg_height) * HCA_W'(p1_ca_abs);
    p2_hc      <= HC_W'(cfg_height) * HC_W'(p1_cabs);
    p2_deny    <= DENY_W'(fx_eff) * DENY_W'(p1_denx);
    p2_ct15    <= p1_ct15;
    p2_denx    <= p1_denx;
    p2_horizon <= p1_horizon;
    p2_ca_neg  <= p1_ca_neg;
    p2_y_neg   <= p1_y_neg;
    p2_rgb     <= p1_rgb;
  end

  // p3: lateral numerator
  logic                p3_valid;
  logic                p3_horizon;
  logic                p3_ca_neg;
  logic                p3_y_neg;
  logic [HCA_W-1:0]    p3_hca;
  logic [NUMY_W-1:0]   p3_numy;
  logic [DENX_W-1:0]   p3_denx;
  logic [DENY_W-1:0]   p3_deny;
  logic [23:0]         p3_rgb;

  always_ff @(posedge clk) begin
    if (rst) begin
      p3_valid <= 1'b0;
    end else begin
      p3_valid <= p2_valid;
    end
  end

  always_ff @(posedge clk) begin
    p3_numy    <= NUMY_W'(p2_hc) * NUMY_W'(p2_ct15);
    p3_hca     <= p2_hca;
    p3_denx    <= p2_denx;
    p3_deny    <= p2_deny;
    p3_horizon <= p2_horizon;
    p3_ca_neg  <= p2_ca_neg;
    p3_y_neg   <= p2_y_neg;
    p3_rgb     <= p2_rgb;
  end

  // saturating quotients
  logic             dx_valid;
  logic [QUO_W-1:0] dx_quo;
  logic             dx_over;
  logic [25:0]      dx_side;
  logic             dy_valid;
  logic [QUO_W-1:0] dy_quo;
  logic             dy_over;
  logic             dy_side;

  fgp_sat_div #(
    .NUM_W  (HCA_W),
    .DEN_W  (DENX_W),
    .SIDE_W (26)
  ) u_div_x (
    .clk       (clk),
    .rst       (rst),
    .valid_in  (p3_valid),
    .num       (p3_hca),
    .den       (p3_denx),
    .side_in   ({p3_rgb, p3_horizon, p3_ca_neg}),
    .valid_out (dx_valid),
    .quo       (dx_quo),
    .over      (dx_over),
    .side_out  (dx_side)
  );

  fgp_sat_div #(
    .NUM_W  (NY_W),
    .DEN_W  (DENY_W),
    .SIDE_W (1)
  ) u_div_y (
    .clk       (clk),
    .rst       (rst),
    .valid_in  (p3_valid),
    .num       ({p3_numy, 15'd0}),
    .den       (p3_deny),
    .side_in   (p3_y_neg),
    .valid_out (dy_valid),
    .quo       (dy_quo),
    .over      (dy_over),
    .side_out  (dy_side)
  );

  // clamp, sign and result register
  logic             fin_horizon;
  logic             fin_x_neg;
  logic [QUO_W-1:0] lim_x;
  logic [QUO_W-1:0] lim_y;
  logic             sat_x;
  logic             sat_y;
  logic [QUO_W-1:0] mag_x;
  logic [QUO_W-1:0] mag_y;
  ground_t          res_next;

  assign fin_horizon = dx_side[1];
  assign fin_x_neg   = dx_side[0];

  always_comb begin
    lim_x = fin_x_neg ? NEG_LIM : POS_LIM;
    lim_y = dy_side ? NEG_LIM : POS_LIM;
    sat_x = dx_over || (dx_quo > lim_x);
    sat_y = dy_over || (dy_quo > lim_y);
    mag_x = sat_x ? lim_x : dx_quo;
    mag_y = sat_y ? lim_y : dy_quo;
    res_next.out_blue  = dx_side[25:18];
    res_next.out_green = dx_side[17:10];
    res_next.out_red   = dx_side[9:2];
    if (fin_horizon) begin
      res_next.ground_forward = $signed(POS_LIM);
      res_next.ground_lateral = '0;
      res_next.saturated      = 1'b1;
    end else begin
      res_next.ground_forward = $signed(fin_x_neg ? -mag_x : mag_x);
      res_next.ground_lateral = $signed(dy_side ? -mag_y : mag_y);
      res_next.saturated      = sat_x || sat_y;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= dx_valid;
    end
  end

  always_ff @(posedge clk) begin
    result <= res_next;
  end

  a_horizon_flag: assert property (@(posedge clk) disable iff (rst)
    p1_valid && p1_horizon |-> ##(QUO_W+4) (done && result.saturated))
    else $error("pixel above the horizon not flagged");

  a_div_aligned: assert property (@(posedge clk) disable iff (rst)
    dy_valid == dx_valid)
    else $error("dividers out of step");

endmodule

>>> hw/rtl/fgp_cordic_vec.sv
module fgp_cordic_vec #(
  parameter int STEPS  = 16,
  parameter int SIDE_W = 1
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             valid_in,
  input  logic signed [fgp_pkg::VX_W-1:0]  x_in,
  input  logic signed [fgp_pkg::VX_W-1:0]  y_in,
  input  logic [SIDE_W-1:0]                side_in,
  output logic                             valid_out,
  output logic signed [fgp_pkg::VZ_W-1:0]  z_out,
  output logic [SIDE_W-1:0]                side_out
);
  import fgp_pkg::*;

  logic                   vld [0:STEPS];
  logic signed [VX_W-1:0] xs  [0:STEPS];
  logic signed [VX_W-1:0] ys  [0:STEPS];
  logic signed [VZ_W-1:0] zs  [0:STEPS];
  logic [SIDE_W-1:0]      sd  [0:STEPS];

  assign vld[0] = valid_in;
  assign xs[0]  = x_in;
  assign ys[0]  = y_in;
  assign zs[0]  = '0;
  assign sd[0]  = side_in;

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      sd[k+1] <= sd[k];
      if (ys[k] >= 0) begin
        xs[k+1] <= xs[k] + (ys[k] >>> k);
        ys[k+1] <= ys[k] - (xs[k] >>> k);
        zs[k+1] <= zs[k] + VZ_W'(ATAN_TAB[k]);
      end else begin
        xs[k+1] <= xs[k] - (ys[k] >>> k);
        ys[k+1] <= ys[k] + (xs[k] >>> k);
        zs[k+1] <= zs[k] - VZ_W'(ATAN_TAB[k]);
      end
    end
  end

  assign valid_out = vld[STEPS];
  assign z_out     = zs[STEPS];
  assign side_out  = sd[STEPS];

  a_vec_latency: assert property (@(posedge clk) disable iff (rst)
    valid_in |-> ##STEPS valid_out)
    else $error("vectoring pipeline lost an item");

endmodule

>>> hw/rtl/fgp_cordic_rot.sv
module fgp_cordic_rot #(
  parameter int STEPS  = 16,
  parameter int SIDE_W = 1
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             valid_in,
  input  logic signed [fgp_pkg::ANG_W-1:0] ang_in [2],
  input  logic [SIDE_W-1:0]                side_in,
  output logic                             valid_out,
  output logic signed [fgp_pkg::CS_W-1:0]  cos_out [2],
  output logic signed [fgp_pkg::CS_W-1:0]  sin_out [2],
  output logic [SIDE_W-1:0]                side_out
);
  import fgp_pkg::*;

  localparam logic signed [ANG_W-1:0] PI_A   = ANG_W'(ANG_PI);
  localparam logic signed [ANG_W-1:0] HALF_A = ANG_W'(ANG_HALF_PI);

  logic                    vld [0:STEPS];
  logic [SIDE_W-1:0]       sd  [0:STEPS];
  logic                    neg [2][0:STEPS];
  logic signed [CS_W-1:0]  xs  [2][0:STEPS];
  logic signed [CS_W-1:0]  ys  [2][0:STEPS];
  logic signed [ANG_W-1:0] as  [2][0:STEPS];
  logic                    vld_out;
  logic [SIDE_W-1:0]       sd_out;

  // fold into [-pi/2, pi/2]
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    sd[0] <= side_in;
  end

  for (genvar l = 0; l < 2; l++) begin : g_fold
    always_ff @(posedge clk) begin
      xs[l][0] <= CS_W'(GAIN_INV);
      ys[l][0] <= '0;
      if (ang_in[l] > HALF_A) begin
        as[l][0]  <= ang_in[l] - PI_A;
        neg[l][0] <= 1'b1;
      end else if (ang_in[l] < -HALF_A) begin
        as[l][0]  <= ang_in[l] + PI_A;
        neg[l][0] <= 1'b1;
      end else begin
        as[l][0]  <= ang_in[l];
        neg[l][0] <= 1'b0;
      end
    end
  end

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      sd[k+1] <= sd[k];
    end

    for (genvar l = 0; l < 2; l++) begin : g_lane
      always_ff @(posedge clk) begin
        neg[l][k+1] <= neg[l][k];
        if (as[l][k] >= 0) begin
          xs[l][k+1] <= xs[l][k] - (ys[l][k] >>> k);
          ys[l][k+1] <= ys[l][k] + (xs[l][k] >>> k);
          as[l][k+1] <= as[l][k] - ANG_W'(ATAN_TAB[k]);
        end else begin
          xs[l][k+1] <= xs[l][k] + (ys[l][k] >>> k);
          ys[l][k+1] <= ys[l][k] - (xs[l][k] >>> k);
          as[l][k+1] <= as[l][k] + ANG_W'(ATAN_TAB[k]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_out <= 1'b0;
    end else begin
      vld_out <= vld[STEPS];
    end
  end

  always_ff @(posedge clk) begin
    sd_out <= sd[STEPS];
    for (int l = 0; l < 2; l++) begin
      cos_out[l] <= neg[l][STEPS] ? -xs[l][STEPS] : xs[l][STEPS];
      sin_out[l] <= neg[l][STEPS] ? -ys[l][STEPS] : ys[l][STEPS];
    end
  end

  assign valid_out = vld_out;
  assign side_out  = sd_out;

endmodule

>>> hw/rtl/fgp_sat_div.sv
module fgp_sat_div #(
  parameter int NUM_W  = 56,
  parameter int DEN_W  = 31,
  parameter int SIDE_W = 1
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       valid_in,
  input  logic [NUM_W-1:0]           num,
  input  logic [DEN_W-1:0]           den,
  input  logic [SIDE_W-1:0]          side_in,
  output logic                       valid_out,
  output logic [fgp_pkg::QUO_W-1:0]  quo,
  output logic                       over,
  output logic [SIDE_W-1:0]          side_out
);
  import fgp_pkg::*;

  localparam int HI_W  = NUM_W - QUO_W;
  localparam int CMP_W = (HI_W > DEN_W) ? HI_W : DEN_W;

  logic              vld [0:QUO_W];
  logic              ovr [0:QUO_W];
  logic [DEN_W-1:0]  rem [0:QUO_W];
  logic [DEN_W-1:0]  dn  [0:QUO_W];
  logic [QUO_W-1:0]  low [0:QUO_W];
  logic [QUO_W-1:0]  qs  [0:QUO_W];
  logic [SIDE_W-1:0] sd  [0:QUO_W];

  // quotient of 2^32 or more saturates
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    ovr[0] <= CMP_W'(num[NUM_W-1:QUO_W]) >= CMP_W'(den);
    rem[0] <= DEN_W'(num[NUM_W-1:QUO_W]);
    low[0] <= num[QUO_W-1:0];
    dn[0]  <= den;
    qs[0]  <= '0;
    sd[0]  <= side_in;
  end

  for (genvar k = 0; k < QUO_W; k++) begin : g_bit
    logic [DEN_W:0] trial;
    logic           ge;

    assign trial = {rem[k], low[k][QUO_W-1]};
    assign ge    = trial >= {1'b0, dn[k]};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      rem[k+1] <= ge ? DEN_W'(trial - {1'b0, dn[k]}) : DEN_W'(trial);
      low[k+1] <= {low[k][QUO_W-2:0], 1'b0};
      qs[k+1]  <= {qs[k][QUO_W-2:0], ge};
      dn[k+1]  <= dn[k];
      ovr[k+1] <= ovr[k];
      sd[k+1]  <= sd[k];
    end
  end

  assign valid_out = vld[QUO_W];
  assign quo       = qs[QUO_W];
  assign over      = ovr[QUO_W];
  assign side_out  = sd[QUO_W];

  a_div_latency: assert property (@(posedge clk) disable iff (rst)
    valid_in |-> ##(QUO_W+1) valid_out)
    else $error("divider pipeline lost an item");

endmodule

>>> tb/flat_ground_pixel_projection_check.sv
module flat_ground_pixel_projection_check
  import fgp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic                 busy,
  input  pixel_t               pixel,
  input  logic                 done,
  input  ground_t              result,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_addr,
  input  logic [CFG_W-1:0]     cfg_wdata,
  output int                   errors,
  output int                   pending
);

  localparam int COORD_BITS   = 12;
  localparam int CORDIC_STEPS = 16;

  logic [15:0] cx;
  logic [15:0] cy;
  logic [19:0] fx_reg;
  logic [23:0] height;
  logic [15:0] pitch;

  ground_t ground_q[$];

  function automatic longint ray_atan(longint x, longint y);
    longint z, xs, ys;
    z = 0;
    for (int i = 0; i < CORDIC_STEPS && i < ATAN_ENTRIES; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x += ys; y -= xs; z += ATAN_TAB[i];
      end else begin
        x -= ys; y += xs; z -= ATAN_TAB[i];
      end
    end
    return z;
  endfunction

  function automatic void rotate(longint a, output longint cs, output longint sn);
    longint x, y, xs, ys;
    bit neg;
    x = GAIN_INV;
    y = 0;
    neg = 0;
    if (a >= ANG_PI) a -= ANG_TWO_PI;
    if (a < -ANG_PI) a += ANG_TWO_PI;
    if (a > ANG_HALF_PI) begin
      a -= ANG_PI; neg = 1;
    end else if (a < -ANG_HALF_PI) begin
      a += ANG_PI; neg = 1;
    end
    for (int i = 0; i < CORDIC_STEPS && i < ATAN_ENTRIES; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (a >= 0) begin
        x -= ys; y += xs; a -= ATAN_TAB[i];
      end else begin
        x += ys; y -= xs; a += ATAN_TAB[i];
      end
    end
    cs = neg ? -x : x;
    sn = neg ? -y : y;
  endfunction

  // quotient num*2^k/den with a clamp on the magnitude
  function automatic longint clamped_quotient(bit negative, longint unsigned num,
                                              longint unsigned den, int k,
                                              inout bit over);
    longint unsigned q, r, lim;
    lim = negative ? 64'd2147483648 : 64'd2147483647;
    q = num / den;
    r = num % den;
    if (q > lim) begin
      over = 1;
      q = lim;
    end else begin
      for (int j = 0; j < k; j++) begin
        r = r << 1;
        q = q << 1;
        if (r >= den) begin
          r -= den; q |= 1;
        end
        if (q > lim) begin
          over = 1;
          q = lim;
          break;
        end
      end
    end
    return negative ? -longint'(q) : longint'(q);
  endfunction

  function automatic ground_t project_pixel(pixel_t p);
    ground_t g;
    longint row, col, fx, h, pa, r16, c16, tv, ang, ca, sa, ct, st, ct15, gx, gy;
    longint unsigned cabs;
    bit over;
    row = p.pixel_row & ((1 << COORD_BITS) - 1);
    col = p.pixel_col & ((1 << COORD_BITS) - 1);
    fx = (fx_reg == 0) ? 1 : fx_reg;
    h = height;
    pa = longint'($signed(pitch));
    r16 = longint'(cy) + 8 - 16 * row;
    c16 = 16 * col - longint'(cx) + 8;
    over = 0;
    tv = -ray_atan(fx * 1048576, r16 * 1048576);
    ang = pa * 2048 + tv;
    rotate(ang, ca, sa);
    rotate(tv, ct, st);
    if (sa <= 0) begin
      gx = 2147483647;
      gy = 0;
      over = 1;
    end else begin
      cabs = (c16 < 0) ? -c16 : c16;
      gx = clamped_quotient(ca < 0, h * ((ca < 0) ? -ca : ca), sa, 0, over);
      ct15 = (ct + 16384) / 32768;
      if (ct15 < 0) ct15 = 0;
      gy = clamped_quotient(c16 > 0, h * cabs * ct15, fx * sa, 15, over);
    end
    g.ground_forward = gx[31:0];
    g.ground_lateral = gy[31:0];
    g.out_blue = p.blue;
    g.out_green = p.green;
    g.out_red = p.red;
    g.saturated = over;
    return g;
  endfunction

  assign pending = ground_q.size();

  always @(posedge clk) begin
    ground_t want;
    int bad;
    bad = 0;
    if (rst) begin
      cx <= 16'd20736;
      cy <= 16'd15552;
      fx_reg <= 20'd32768;
      height <= 24'd65536;
      pitch <= 16'd0;
      ground_q.delete();
      errors <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_addr))
          REG_PRINCIPAL_COL: cx <= cfg_wdata[15:0];
          REG_PRINCIPAL_ROW: cy <= cfg_wdata[15:0];
          REG_FOCAL_LENGTH:  fx_reg <= cfg_wdata[19:0];
          REG_CAMERA_HEIGHT: height <= cfg_wdata[23:0];
          REG_PITCH_ANGLE:   pitch <= cfg_wdata[15:0];
          default: ;
        endcase
      end
      if (start && !busy) ground_q = {ground_q, project_pixel(pixel)};
      if (done) begin
        if (ground_q.size() == 0) begin
          $error("result transfer with nothing expected");
          bad++;
        end else begin
          want = ground_q.pop_front();
          if (result.ground_forward !== want.ground_forward) begin
            $error("ground_forward expected %0d got %0d", want.ground_forward,
                   result.ground_forward);
            bad++;
          end
          if (result.ground_lateral !== want.ground_lateral) begin
            $error("ground_lateral expected %0d got %0d", want.ground_lateral,
                   result.ground_lateral);
            bad++;
          end
          if (result.out_blue !== want.out_blue) begin
            $error("out_blue expected %0d got %0d", want.out_blue, result.out_blue);
            bad++;
          end
          if (result.out_green !== want.out_green) begin
            $error("out_green expected %0d got %0d", want.out_green, result.out_green);
            bad++;
          end
          if (result.out_red !== want.out_red) begin
            $error("out_red expected %0d got %0d", want.out_red, result.out_red);
            bad++;
          end
          if (result.saturated !== want.saturated) begin
            $error("saturated expected %0d got %0d", want.saturated, result.saturated);
            bad++;
          end
        end
      end
      errors <= errors + bad;
    end
  end

endmodule

>>> tb/flat_ground_pixel_projection_test.sv
module flat_ground_pixel_projection_test;
  import fgp_pkg::*;

  localparam int LATENCY = 2 * 16 + 41;

  logic                 clk;
  logic                 rst;
  logic                 start;
  logic                 busy;
  pixel_t               pixel;
  logic                 done;
  ground_t              result;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_addr;
  logic [CFG_W-1:0]     cfg_wdata;
  int                   errors;
  int                   pending;
  int                   burst_left;

  flat_ground_pixel_projection DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .pixel(pixel),
    .done(done), .result(result), .cfg_we(cfg_we), .cfg_addr(cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  flat_ground_pixel_projection_check checker_i (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .pixel(pixel),
    .done(done), .result(result), .cfg_we(cfg_we), .cfg_addr(cfg_addr),
    .cfg_wdata(cfg_wdata), .errors(errors), .pending(pending)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3000000;
    $display("** flat_ground_pixel_projection: FAILED **");
    $finish;
  end

  task automatic drain();
    start <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CFG_W-1:0] val);
    cfg_we <= 1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic set_camera(logic [15:0] ccol, logic [15:0] crow, logic [19:0] f,
                            logic [23:0] h, logic signed [15:0] pa);
    drain();
    write_reg(REG_PRINCIPAL_COL, {8'd0, ccol});
    write_reg(REG_PRINCIPAL_ROW, {8'd0, crow});
    write_reg(REG_FOCAL_LENGTH, {4'd0, f});
    write_reg(REG_CAMERA_HEIGHT, h);
    write_reg(REG_PITCH_ANGLE, {8'd0, pa});
    cfg_we <= 0;
  endtask

  // bursts of random length with random gaps, long stretches without gaps
  task automatic send(logic [11:0] r, logic [11:0] c, logic [7:0] b, logic [7:0] g,
                      logic [7:0] rd);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
    end
    burst_left--;
    if (gap > 0) begin
      start <= 0;
      repeat (gap) @(posedge clk);
    end
    start <= 1;
    pixel <= '{pixel_row: r, pixel_col: c, blue: b, green: g, red: rd};
    do @(posedge clk); while (busy);
  endtask

  task automatic send_random(int n);
    logic [11:0] r;
    for (int i = 0; i < n; i++) begin
      // mostly below the optical centre so most rays hit the ground
      r = ($urandom_range(0, 3) == 0) ? 12'($urandom_range(0, 4095))
                                      : 12'($urandom_range(900, 4095));
      send(r, 12'($urandom_range(0, 4095)), 8'($urandom_range(0, 255)),
           8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    rst = 1;
    start = 0;
    pixel = '0;
    cfg_we = 0;
    cfg_addr = '0;
    cfg_wdata = '0;
    burst_left = 0;
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: corners, colour extremes, horizon, overflow
    send(12'd0, 12'd0, 8'd0, 8'd0, 8'd0);
    send(12'd4095, 12'd4095, 8'd255, 8'd255, 8'd255);
    send(12'd0, 12'd4095, 8'hAA, 8'h55, 8'hF0);
    send(12'd4095, 12'd0, 8'h55, 8'hAA, 8'h0F);
    send(12'd972, 12'd1296, 8'd1, 8'd2, 8'd3);
    send(12'd971, 12'd1295, 8'd4, 8'd5, 8'd6);
    send(12'd973, 12'd1297, 8'd7, 8'd8, 8'd9);
    send(12'd2000, 12'd2048, 8'd10, 8'd11, 8'd12);
    set_camera(16'd20736, 16'd15552, 20'd1, 24'hFFFFFF, 16'sd4000);
    send(12'd4095, 12'd4095, 8'd1, 8'd1, 8'd1);
    send(12'd4095, 12'd0, 8'd2, 8'd2, 8'd2);
    send(12'd1000, 12'd1296, 8'd3, 8'd3, 8'd3);
    set_camera(16'd0, 16'd65535, 20'd0, 24'd0, 16'sd25736);
    send(12'd0, 12'd0, 8'd4, 8'd4, 8'd4);
    send(12'd4095, 12'd4095, 8'd5, 8'd5, 8'd5);
    send(12'd2048, 12'd100, 8'd6, 8'd6, 8'd6);
    set_camera(16'd65535, 16'd0, 20'd1048575, 24'd65536, -16'sd25736);
    send(12'd0, 12'd0, 8'd7, 8'd7, 8'd7);
    send(12'd4095, 12'd4095, 8'd8, 8'd8, 8'd8);
    set_camera(16'd20736, 16'd15552, 20'd32768, 24'd65536, 16'sd20000);
    send(12'd0, 12'd2000, 8'd9, 8'd9, 8'd9);
    send(12'd4095, 12'd2000, 8'd10, 8'd10, 8'd10);

    set_camera(16'd20736, 16'd15552, 20'd32768, 24'd65536, 16'sd0);
    send_random(200);
    set_camera(16'd32768, 16'd32768, 20'd40000, 24'd131072, 16'sd3000);
    send_random(200);
    set_camera(16'd65535, 16'd65535, 20'd1048575, 24'hFFFFFF, 16'sd25736);
    send_random(150);
    set_camera(16'd0, 16'd0, 20'd1, 24'd1, -16'sd25736);
    send_random(150);
    for (int k = 0; k < 4; k++) begin
      set_camera(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                 20'($urandom_range(1, 1048575)), 24'($urandom_range(0, 16777215)),
                 $signed(16'($urandom_range(0, 51472))) - 16'sd25736);
      send_random(150);
    end

    drain();
    repeat (LATENCY + 10) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("** flat_ground_pixel_projection: PASSED **");
    end else begin
      $display("** flat_ground_pixel_projection: FAILED **");
    end
    $finish;
  end

endmodule
